### sv/pwm_timebase_duty_calc_core_assert.svh
// ---------------------------------------------------------------------------
// PWM time base assertion macros
// Shared concurrent assertion forms for the PWM time base calculator.
// ---------------------------------------------------------------------------
`ifndef PWM_TIMEBASE_DUTY_CALC_CORE_ASSERT_SVH
`define PWM_TIMEBASE_DUTY_CALC_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PWM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, forces a consequence in the same cycle.
`define PWM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### sv/pwm_tbd_pkg.sv
// ---------------------------------------------------------------------------
// PWM time base package
// Shared constants and pipeline sideband types for the PWM calculator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwm_tbd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CfgBaseClock  = 2'd0;
    localparam logic [1:0] CfgWideCount  = 2'd1;
    localparam logic [1:0] CfgResolution = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] ResetBaseClock  = 32'd60000000;
    localparam logic [4:0]  ResetResolution = 5'd8;

    // Narrow counter span and prescaler ceiling.
    localparam logic [16:0] NarrowSpan   = 17'd65535;
    localparam logic [17:0] PrescCeiling = 18'd65536;

    // Sideband carried through the cycle-count divider.
    typedef struct packed {
        logic        ok;
        logic        full_hit;
        logic        wide;
        logic [31:0] duty;
        logic [30:0] full;
    } side1_t;

    // Sideband carried through the period divider.
    typedef struct packed {
        logic        ok;
        logic        full_hit;
        logic [31:0] duty;
        logic [30:0] full;
        logic [15:0] presc_m1;
    } side2_t;

    // Sideband carried through the compare divider.
    typedef struct packed {
        logic        ok;
        logic        full_hit;
        logic [15:0] presc_m1;
        logic [31:0] period;
    } side3_t;

endpackage

### sv/pwm_tbd_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with sideband carried alongside.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwm_tbd_div
    import pwm_tbd_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int SW = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] nq_reg   [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar i = 0; i < NW; i++) begin : g_stage
        logic          vld_src;
        logic [DW-1:0] rem_src;
        logic [NW-1:0] nq_src;
        logic [DW-1:0] den_src;
        logic [SW-1:0] side_src;
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] nq_next;

        // Stage input: the ports for the first stage, else the previous stage.
        if (i == 0) begin : g_first
            assign vld_src  = in_valid;
            assign rem_src  = '0;
            assign nq_src   = num;
            assign den_src  = den;
            assign side_src = side;
        end
        else begin : g_next
            assign vld_src  = vld_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign nq_src   = nq_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        // Shift in one numerator bit and subtract when the divisor fits.
        always_comb
        begin
            trial    = {rem_src, nq_src[NW-1]};
            ge       = (trial >= {1'b0, den_src});
            rem_next = ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
            nq_next  = {nq_src[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                nq_reg[i]   <= nq_next;
                den_reg[i]  <= den_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign quo       = nq_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

### sv/pwm_timebase_duty_calc_core.sv
// ---------------------------------------------------------------------------
// PWM time base and duty calculator
// Turns a requested frequency and duty value into prescaler, period and
// compare register values.
// ---------------------------------------------------------------------------
// Usage: requests arrive on the in channel (frequency_hz, duty_value) and
// results leave on the out channel (accepted, prescaler_reg, period_reg,
// compare_reg), both valid/ready. One transfer is taken every cycle unless the receiver stalls.
// Stages in order: 32 stages divide the base clock by the frequency, one
// stage forms the prescaler, 33 stages divide for the period, one stage
// multiplies duty by period, 64 stages divide for the compare value and one
// output register holds the result.
// The whole pipeline moves as one; when the receiver stalls with a result
// waiting, every stage holds and in_ready falls, so nothing is lost.
// Configuration writes through cfg_wr_en, cfg_addr and cfg_wdata take effect
// at once; the user must make them only while the pipeline is empty, as the block does not enforce this.
// Reset clears all valid bits and loads a 60 MHz base clock, the 16-bit
// counter and 8-bit duty resolution.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwm_timebase_duty_calc_core
    import pwm_tbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] frequency_hz,
    input  logic [31:0] duty_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [15:0] prescaler_reg,
    output logic [31:0] period_reg,
    output logic [32:0] compare_reg
);

`include "pwm_timebase_duty_calc_core_assert.svh"

    logic [31:0] base_clk_reg;
    logic        wide_reg;
    logic [4:0]  res_reg;
    logic        adv;

    // Configuration registers; a resolution below 2 or beyond the counter is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_clk_reg <= ResetBaseClock;
            wide_reg     <= 1'b0;
            res_reg      <= ResetResolution;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CfgBaseClock:  base_clk_reg <= cfg_wdata;
                CfgWideCount:  wide_reg     <= cfg_wdata[0];
                CfgResolution:
                begin
                    if (cfg_wdata[4:0] >= 5'd2 &&
                        cfg_wdata[4:0] <= (wide_reg ? 5'd31 : 5'd15))
                        res_reg <= cfg_wdata[4:0];
                end
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register can take a result.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Request check ahead of the first divider.
    side1_t      s1_in;
    logic [31:0] full_w;
    logic [31:0] max_freq;

    always_comb
    begin
        full_w         = (32'd1 << res_reg) - 32'd1;
        max_freq       = base_clk_reg >> res_reg;
        s1_in.ok       = (frequency_hz != 32'd0) && (frequency_hz <= max_freq) &&
                         (duty_value <= full_w);
        s1_in.full_hit = (duty_value == full_w);
        s1_in.wide     = wide_reg;
        s1_in.duty     = duty_value;
        s1_in.full     = full_w[30:0];
    end

    // Cycle count: base clock over frequency.
    logic        d1_vld;
    logic [31:0] cycles;
    side1_t      s1_out;

    pwm_tbd_div #(.NW(32), .DW(32), .SW($bits(side1_t))) u_div_cycles (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (in_valid),
        .num      (base_clk_reg),
        .den      (frequency_hz),
        .side     (s1_in),
        .out_valid(d1_vld),
        .quo      (cycles),
        .out_side (s1_out)
    );

    // Prescaler from the cycle count, with the rounding term for the period.
    logic [16:0] hi;
    logic [16:0] rsum;
    logic [16:0] q_div;
    logic [17:0] presc_w;
    logic [16:0] presc_next;
    logic [32:0] num2_next;
    side2_t      s2_next;
    logic        p_vld_reg;
    logic [16:0] presc_reg;
    logic [32:0] num2_reg;
    side2_t      s2_reg;

    always_comb
    begin
        hi   = {1'b0, cycles[31:16]};
        rsum = {1'b0, cycles[15:0]} + hi;
        if (s1_out.wide)
            q_div = (cycles == 32'hFFFF_FFFF) ? 17'd1 : 17'd0;
        else if (rsum >= 17'(2 * NarrowSpan))
            q_div = hi + 17'd2;
        else if (rsum >= NarrowSpan)
            q_div = hi + 17'd1;
        else
            q_div = hi;
        presc_w = {1'b0, q_div} + 18'd1;
        if (presc_w > PrescCeiling)
            presc_w = PrescCeiling;
        presc_next        = presc_w[16:0];
        num2_next         = {1'b0, cycles} + {17'd0, presc_next[16:1]};
        s2_next.ok        = s1_out.ok;
        s2_next.full_hit  = s1_out.full_hit;
        s2_next.duty      = s1_out.duty;
        s2_next.full      = s1_out.full;
        s2_next.presc_m1  = 16'(presc_next - 17'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (adv)
            p_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            presc_reg <= presc_next;
            num2_reg  <= num2_next;
            s2_reg    <= s2_next;
        end
    end

    // Period: cycle count over prescaler, rounded to nearest.
    logic        d2_vld;
    logic [32:0] period_q;
    side2_t      s2_out;

    pwm_tbd_div #(.NW(33), .DW(17), .SW($bits(side2_t))) u_div_period (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (p_vld_reg),
        .num      (num2_reg),
        .den      (presc_reg),
        .side     (s2_reg),
        .out_valid(d2_vld),
        .quo      (period_q),
        .out_side (s2_out)
    );

    // Duty times period.
    logic        m_vld_reg;
    logic [63:0] prod_reg;
    logic [30:0] full_reg;
    side3_t      s3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if (adv)
            m_vld_reg <= d2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg        <= 64'(s2_out.duty) * 64'(period_q[31:0]);
            full_reg        <= s2_out.full;
            s3_reg.ok       <= s2_out.ok;
            s3_reg.full_hit <= s2_out.full_hit;
            s3_reg.presc_m1 <= s2_out.presc_m1;
            s3_reg.period   <= period_q[31:0];
        end
    end

    // Compare: product over full scale, rounded to nearest.
    logic        d3_vld;
    logic [63:0] cmp_q;
    side3_t      s3_out;

    pwm_tbd_div #(.NW(64), .DW(31), .SW($bits(side3_t))) u_div_compare (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (m_vld_reg),
        .num      (prod_reg + {34'd0, full_reg[30:1]}),
        .den      (full_reg),
        .side     (s3_reg),
        .out_valid(d3_vld),
        .quo      (cmp_q),
        .out_side (s3_out)
    );

    // Output register; a rejected request reads as all zeros.
    logic        out_vld_reg;
    logic        acc_reg;
    logic [15:0] presc_out_reg;
    logic [31:0] period_out_reg;
    logic [32:0] cmp_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= d3_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg        <= s3_out.ok;
            presc_out_reg  <= s3_out.ok ? s3_out.presc_m1 : 16'd0;
            period_out_reg <= s3_out.ok ? s3_out.period : 32'd0;
            if (!s3_out.ok)
                cmp_out_reg <= 33'd0;
            else if (s3_out.full_hit)
                cmp_out_reg <= {1'b0, s3_out.period} + 33'd1;
            else
                cmp_out_reg <= cmp_q[32:0];
        end
    end

    assign out_valid     = out_vld_reg;
    assign accepted      = acc_reg;
    assign prescaler_reg = presc_out_reg;
    assign period_reg    = period_out_reg;
    assign compare_reg   = cmp_out_reg;

    // Checks on the pipeline control and the result fields.
    `PWM_ASSERT_ALWAYS(a_ready_tracks_output, in_ready == (!out_valid || out_ready), "in_ready does not follow the output register")
    `PWM_ASSERT_IMPLY(a_reject_zero, out_valid && !accepted, prescaler_reg == 16'd0 && period_reg == 32'd0 && compare_reg == 33'd0, "rejected result carries non-zero fields")
    `PWM_ASSERT_IMPLY(a_compare_bound, out_valid && accepted, compare_reg <= ({1'b0, period_reg} + 33'd1), "compare value exceeds period plus one")

endmodule
